// ===== hdl/wnam_pkg.sv =====
// ----------------------------------------------------------------------------
// wnam_pkg
// Shared types, widths and helpers for the wavetable and noise audio mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package wnam_pkg;

	// Field and state widths
	localparam int WAVE_DEPTH   = 256;
	localparam int WAVE_AW      = $clog2(WAVE_DEPTH);
	localparam int WAVE_W       = 8;
	localparam int PHASE_W      = 16;
	localparam int VOL_W        = 8;
	localparam int NUM_WAVE     = 3;
	localparam int NUM_TERM     = NUM_WAVE + 1;
	localparam int NOISE_W      = 14;
	localparam int NOISE_CNT_W  = 7;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int SAMPLE_W     = 11;
	localparam int VOL_SHIFT    = 3;
	localparam int MIX_SHIFT    = 4;
	localparam int PROD_W       = WAVE_W + VOL_W;
	localparam int TERM_W       = PROD_W - VOL_SHIFT;
	localparam int SUM_W        = TERM_W + $clog2(NUM_TERM);

	localparam logic [NOISE_W-1:0] NOISE_SEED = 14'h0101;

	// Input operation codes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_A     = 3'd0,
		CFG_STEP_B     = 3'd1,
		CFG_STEP_C     = 3'd2,
		CFG_VOL_A      = 3'd3,
		CFG_VOL_B      = 3'd4,
		CFG_VOL_C      = 3'd5,
		CFG_NOISE_VOL  = 3'd6,
		CFG_NOISE_CTRL = 3'd7
	} cfg_reg_t;

	// Scale an unsigned byte by a volume and drop the low fraction bits
	function automatic logic [TERM_W-1:0] scale_term(input logic [WAVE_W-1:0] smp,
			input logic [VOL_W-1:0] vol);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(smp) * PROD_W'(vol);
		return prod[PROD_W-1:VOL_SHIFT];
	endfunction

	// Advance the noise LFSR by one step
	function automatic logic [NOISE_W-1:0] lfsr_next(input logic [NOISE_W-1:0] cur,
			input logic long_mode);
		logic                fb;
		logic [NOISE_W-1:0]  nxt;
		fb  = cur[0] ^ cur[1];
		nxt = {fb, cur[NOISE_W-1:1]};
		if (!long_mode) begin
			nxt[5] = fb;
		end
		return nxt;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/wavetable_noise_audio_mixer.sv =====
// ----------------------------------------------------------------------------
// wavetable_noise_audio_mixer
// Three wavetable voices and an LFSR noise voice mixed into one sample.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while in_ready is high. A tick beat with
// the engine on has its wave-table reads registered in the read stage, and its
// mixed sample then loads from there into the result register. A wave-table
// write beat and an engine-off tick give no sample. The volume multiplies and
// the mix are short combinational logic between the read-stage register and
// the result register. Each voice has its own copy of the wave
// table, so the three reads of one tick happen in the same cycle; writes go to
// all copies. The read stage fills while a finished sample waits at the
// output. A stall is only seen at the input once both the read stage and the
// result register hold a sample.
`default_nettype none

module wavetable_noise_audio_mixer (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration
	input  wire logic                                  cfg_we,
	input  wire logic [wnam_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [wnam_pkg::CFG_W-1:0]            cfg_data,
	// input channel
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  op,
	input  wire logic [wnam_pkg::WAVE_AW-1:0]          wave_index,
	input  wire logic signed [wnam_pkg::WAVE_W-1:0]    wave_value,
	input  wire logic                                  engine_on,
	// output channel
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [wnam_pkg::SAMPLE_W-1:0]              mixed_sample
);

	// Configuration registers
	logic [wnam_pkg::PHASE_W-1:0]  step_q [wnam_pkg::NUM_WAVE];
	logic [wnam_pkg::VOL_W-1:0]    vol_q  [wnam_pkg::NUM_WAVE];
	logic [wnam_pkg::VOL_W-1:0]    noise_vol_q;
	logic [wnam_pkg::VOL_W-1:0]    noise_ctrl_q;

	// Voice state
	logic [wnam_pkg::PHASE_W-1:0]      phase_q   [wnam_pkg::NUM_WAVE];
	logic [wnam_pkg::PHASE_W-1:0]      phase_nxt [wnam_pkg::NUM_WAVE];
	logic [wnam_pkg::NOISE_W-1:0]      noise_shift_q;
	logic [wnam_pkg::NOISE_CNT_W-1:0]  noise_count_q;
	logic [wnam_pkg::NOISE_W-1:0]      noise_shift_nxt;

	// Pipeline
	logic                              v_s1;
	logic [wnam_pkg::WAVE_W-1:0]       rd_s1 [wnam_pkg::NUM_WAVE];
	logic [wnam_pkg::WAVE_W-1:0]       noise_byte_s1;
	logic [wnam_pkg::TERM_W-1:0]       term [wnam_pkg::NUM_TERM];
	logic [wnam_pkg::SUM_W-1:0]        mix_sum;

	logic en_s1;
	logic en_out;
	logic in_beat;
	logic tick_beat;
	logic wr_beat;

	// Stage enables: a stage loads when it is empty or its contents move on
	assign en_out    = !out_valid || out_ready;
	assign en_s1     = !v_s1 || en_out;
	assign in_ready  = en_s1;
	assign in_beat   = in_valid && in_ready;
	assign wr_beat   = in_beat && (op == wnam_pkg::OP_WRITE);
	assign tick_beat = in_beat && (op == wnam_pkg::OP_TICK) && engine_on;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wnam_pkg::NUM_WAVE; i++) begin
				step_q[i] <= '0;
				vol_q[i]  <= '0;
			end
			noise_vol_q  <= '0;
			noise_ctrl_q <= '0;
		end else if (cfg_we) begin
			case (wnam_pkg::cfg_reg_t'(cfg_index))
				wnam_pkg::CFG_STEP_A:     step_q[0]    <= cfg_data;
				wnam_pkg::CFG_STEP_B:     step_q[1]    <= cfg_data;
				wnam_pkg::CFG_STEP_C:     step_q[2]    <= cfg_data;
				wnam_pkg::CFG_VOL_A:      vol_q[0]     <= cfg_data[wnam_pkg::VOL_W-1:0];
				wnam_pkg::CFG_VOL_B:      vol_q[1]     <= cfg_data[wnam_pkg::VOL_W-1:0];
				wnam_pkg::CFG_VOL_C:      vol_q[2]     <= cfg_data[wnam_pkg::VOL_W-1:0];
				wnam_pkg::CFG_NOISE_VOL:  noise_vol_q  <= cfg_data[wnam_pkg::VOL_W-1:0];
				wnam_pkg::CFG_NOISE_CTRL: noise_ctrl_q <= cfg_data[wnam_pkg::VOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance phases and the noise generator on a tick beat
	always_comb begin
		for (int i = 0; i < wnam_pkg::NUM_WAVE; i++) begin
			phase_nxt[i] = phase_q[i] + step_q[i];
		end
		if (noise_count_q == '0) begin
			noise_shift_nxt = wnam_pkg::lfsr_next(noise_shift_q, noise_ctrl_q[0]);
		end else begin
			noise_shift_nxt = noise_shift_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wnam_pkg::NUM_WAVE; i++) begin
				phase_q[i] <= '0;
			end
			noise_shift_q <= wnam_pkg::NOISE_SEED;
			noise_count_q <= '0;
		end else if (tick_beat) begin
			for (int i = 0; i < wnam_pkg::NUM_WAVE; i++) begin
				phase_q[i] <= phase_nxt[i];
			end
			noise_shift_q <= noise_shift_nxt;
			if (noise_count_q == '0) begin
				noise_count_q <= noise_ctrl_q[wnam_pkg::VOL_W-1:1];
			end else begin
				noise_count_q <= noise_count_q - 1'b1;
			end
		end
	end

	// Wave table, one copy per voice: write all copies, read at the new phase
	for (genvar ch = 0; ch < wnam_pkg::NUM_WAVE; ch++) begin : g_voice
		logic [wnam_pkg::WAVE_W-1:0] wave_mem [wnam_pkg::WAVE_DEPTH];

		always_ff @(posedge clk) begin
			if (wr_beat) begin
				wave_mem[wave_index] <= wave_value;
			end
			if (en_s1) begin
				rd_s1[ch] <= wave_mem[phase_nxt[ch][wnam_pkg::PHASE_W-1 -: wnam_pkg::WAVE_AW]];
			end
		end
	end

	// Stage 1 control and noise byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= tick_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			noise_byte_s1 <= noise_shift_nxt[wnam_pkg::WAVE_W-1:0];
		end
	end

	// Offset wave bytes to unsigned, apply volumes and mix the four terms
	always_comb begin
		for (int i = 0; i < wnam_pkg::NUM_WAVE; i++) begin
			term[i] = wnam_pkg::scale_term({~rd_s1[i][wnam_pkg::WAVE_W-1],
				rd_s1[i][wnam_pkg::WAVE_W-2:0]}, vol_q[i]);
		end
		term[wnam_pkg::NUM_WAVE] = wnam_pkg::scale_term(noise_byte_s1, noise_vol_q);
		mix_sum = '0;
		for (int i = 0; i < wnam_pkg::NUM_TERM; i++) begin
			mix_sum = mix_sum + wnam_pkg::SUM_W'(term[i]);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s1) begin
			mixed_sample <= mix_sum[wnam_pkg::MIX_SHIFT +: wnam_pkg::SAMPLE_W];
		end
	end

	// Checks
	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while result register is free");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		wr_beat |=> !v_s1)
		else $error("table write beat entered the sample pipeline");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid && !out_ready) |=> v_s1)
		else $error("stage 1 sample lost while output stalled");

	a_tick_enters: assert property (@(posedge clk) disable iff (!arst_n)
		tick_beat |=> v_s1)
		else $error("tick beat did not reach stage 1");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wavetable and noise audio mixer. It loads the
// wave table, runs a short table of directed beats, then random beats over
// several register settings and idle patterns. Every mixed sample is checked
// against a predictor that tracks phases, the noise LFSR and the table.
// ----------------------------------------------------------------------------

module testbench;
	import wnam_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 8;
	localparam int RAND_BEATS  = 600;
	localparam int NUM_PHASES  = 8;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
	typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic                  op;
		logic [WAVE_AW-1:0]    idx;
		logic [WAVE_W-1:0]     val;
		logic                  eng;
		cfg_reg_t              reg_idx;
		logic [CFG_W-1:0]      reg_data;
		bit                    known;
		logic [SAMPLE_W-1:0]   known_smp;
	} row_t;

	// Block ports
	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index  = '0;
	logic [CFG_W-1:0]            cfg_data   = '0;
	logic                        in_valid   = 1'b0;
	logic                        in_ready;
	logic                        op         = 1'b0;
	logic [WAVE_AW-1:0]          wave_index = '0;
	logic signed [WAVE_W-1:0]    wave_value = '0;
	logic                        engine_on  = 1'b0;
	logic                        out_valid;
	logic                        out_ready  = 1'b0;
	logic [SAMPLE_W-1:0]         mixed_sample;

	// Predictor state and register copies
	logic [PHASE_W-1:0]          step_q [NUM_WAVE];
	logic [VOL_W-1:0]            vol_q [NUM_WAVE];
	logic [VOL_W-1:0]            nvol_q;
	logic [7:0]                  nctrl_q;
	logic [PHASE_W-1:0]          phase_q [NUM_WAVE];
	logic [NOISE_W-1:0]          lfsr_q;
	logic [NOISE_CNT_W-1:0]      div_q;
	logic [WAVE_W-1:0]           wave_mem [WAVE_DEPTH];

	logic [SAMPLE_W-1:0]         pending_samples [$];
	logic [SAMPLE_W-1:0]         want_smp;
	row_t                        dir_rows [$];
	idle_mode_t                  idle_mode    = IDLE_NONE;
	int                          rx_hold_left = 0;
	int                          fail_count   = 0;
	int                          cycle_count  = 0;
	int                          ph;
	int                          n;
	int                          quota;
	bit                          counted;

	wavetable_noise_audio_mixer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.wave_index   (wave_index),
		.wave_value   (wave_value),
		.engine_on    (engine_on),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mixed_sample (mixed_sample)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic bit chance(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	// Advance the predictor by one accepted beat and queue its sample, if any
	task automatic mix_predict(input logic b_op, input logic [WAVE_AW-1:0] b_idx,
			input logic [WAVE_W-1:0] b_val, input logic b_eng, input bit known,
			input logic [SAMPLE_W-1:0] known_smp);
		logic [WAVE_W-1:0] biased;
		int unsigned       total;
		logic              fb;
		int                ch;
		if (b_op == OP_WRITE) begin
			wave_mem[b_idx] = b_val;
			return;
		end
		if (!b_eng) begin
			return;
		end
		total = 0;
		for (ch = 0; ch < NUM_WAVE; ch++) begin
			phase_q[ch] = phase_q[ch] + step_q[ch];
			// signed byte plus 128 is a flip of the sign bit
			biased = wave_mem[phase_q[ch][PHASE_W-1:PHASE_W-WAVE_AW]] ^ 8'h80;
			total += (32'(biased) * 32'(vol_q[ch])) >> VOL_SHIFT;
		end
		// clock the LFSR when the divider has run out, else count down
		if (div_q == '0) begin
			fb     = lfsr_q[0] ^ lfsr_q[1];
			div_q  = nctrl_q[7:1];
			lfsr_q = {fb, lfsr_q[NOISE_W-1:1]};
			if (!nctrl_q[0]) begin
				lfsr_q[5] = fb;
			end
		end else begin
			div_q = div_q - 1'b1;
		end
		total += (32'(lfsr_q[7:0]) * 32'(nvol_q)) >> VOL_SHIFT;
		pending_samples.push_back(known ? known_smp : SAMPLE_W'(total >> MIX_SHIFT));
	endtask

	// Write one register; cfg_we stays high so that writes can follow back to back
	task automatic reg_write(input cfg_reg_t r, input logic [CFG_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		@(negedge clk);
		case (r)
			CFG_STEP_A:     step_q[0] = d;
			CFG_STEP_B:     step_q[1] = d;
			CFG_STEP_C:     step_q[2] = d;
			CFG_VOL_A:      vol_q[0]  = d[VOL_W-1:0];
			CFG_VOL_B:      vol_q[1]  = d[VOL_W-1:0];
			CFG_VOL_C:      vol_q[2]  = d[VOL_W-1:0];
			CFG_NOISE_VOL:  nvol_q    = d[VOL_W-1:0];
			CFG_NOISE_CTRL: nctrl_q   = d[7:0];
			default: ;
		endcase
	endtask

	// Hold off new beats until every sample has come out and the pipe is empty
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic load_regs(input logic [CFG_W-1:0] sa, input logic [CFG_W-1:0] sb,
			input logic [CFG_W-1:0] sc, input logic [7:0] va, input logic [7:0] vb,
			input logic [7:0] vc, input logic [7:0] nv, input logic [7:0] nc);
		wait_drained();
		reg_write(CFG_STEP_A, sa);
		reg_write(CFG_STEP_B, sb);
		reg_write(CFG_STEP_C, sc);
		reg_write(CFG_VOL_A, CFG_W'(va));
		reg_write(CFG_VOL_B, CFG_W'(vb));
		reg_write(CFG_VOL_C, CFG_W'(vc));
		reg_write(CFG_NOISE_VOL, CFG_W'(nv));
		reg_write(CFG_NOISE_CTRL, CFG_W'(nc));
	endtask

	// Offer one beat after an optional gap and wait for the handshake
	task automatic send_beat(input logic b_op, input logic [WAVE_AW-1:0] b_idx,
			input logic [WAVE_W-1:0] b_val, input logic b_eng, input bit known,
			input logic [SAMPLE_W-1:0] known_smp);
		int pct;
		pct = (idle_mode == IDLE_SEND) ? 65 : (idle_mode == IDLE_BOTH) ? 20 : 0;
		if (cfg_we) begin
			cfg_we <= 1'b0;
		end
		while (chance(pct)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		op         <= b_op;
		wave_index <= b_idx;
		wave_value <= b_val;
		engine_on  <= b_eng;
		do begin
			@(posedge clk);
		end while (!in_ready);
		mix_predict(b_op, b_idx, b_val, b_eng, known, known_smp);
		@(negedge clk);
	endtask

	// Random beat: mostly engine-on ticks, some table writes, some idle ticks
	task automatic random_beat(output bit useful);
		int roll;
		roll = $urandom_range(99);
		if (roll < 25) begin
			send_beat(OP_WRITE, WAVE_AW'($urandom), WAVE_W'($urandom), 1'($urandom), 1'b0, '0);
			useful = 1'b1;
		end else if (roll < 35) begin
			send_beat(OP_TICK, WAVE_AW'($urandom), WAVE_W'($urandom), 1'b0, 1'b0, '0);
			useful = 1'b0;
		end else begin
			send_beat(OP_TICK, WAVE_AW'($urandom), WAVE_W'($urandom), 1'b1, 1'b0, '0);
			useful = 1'b1;
		end
	endtask

	function automatic void dir_beat(input logic b_op, input logic [WAVE_AW-1:0] b_idx,
			input logic [WAVE_W-1:0] b_val, input logic b_eng, input bit known,
			input logic [SAMPLE_W-1:0] smp);
		row_t row;
		row.kind      = ROW_BEAT;
		row.op        = b_op;
		row.idx       = b_idx;
		row.val       = b_val;
		row.eng       = b_eng;
		row.reg_idx   = CFG_STEP_A;
		row.reg_data  = '0;
		row.known     = known;
		row.known_smp = smp;
		dir_rows.push_back(row);
	endfunction

	function automatic void dir_reg(input cfg_reg_t r, input logic [CFG_W-1:0] d);
		row_t row;
		row.kind      = ROW_REG;
		row.op        = OP_TICK;
		row.idx       = '0;
		row.val       = '0;
		row.eng       = 1'b0;
		row.reg_idx   = r;
		row.reg_data  = d;
		row.known     = 1'b0;
		row.known_smp = '0;
		dir_rows.push_back(row);
	endfunction

	// Drive the output side: long hold-off when asked, otherwise random stalls
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !chance((idle_mode == IDLE_RECV) ? 65 :
				(idle_mode == IDLE_BOTH) ? 20 : 0);
		end
	end

	// Compare each output beat with the oldest queued sample
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_samples.size() == 0) begin
				$display("%0t: expected no sample, got mixed_sample %0d", $time, mixed_sample);
				fail_count++;
			end else begin
				want_smp = pending_samples.pop_front();
				if (mixed_sample !== want_smp) begin
					$display("%0t: mixed_sample expected %0d, got %0d", $time, want_smp,
						mixed_sample);
					fail_count++;
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		// predictor reset state
		for (n = 0; n < NUM_WAVE; n++) begin
			step_q[n]  = '0;
			vol_q[n]   = '0;
			phase_q[n] = '0;
		end
		for (n = 0; n < WAVE_DEPTH; n++) begin
			wave_mem[n] = '0;
		end
		nvol_q  = '0;
		nctrl_q = '0;
		lfsr_q  = NOISE_SEED;
		div_q   = '0;

		// every volume is zero after reset, so the first tick is silent
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b1, '0);
		// engine off: no sample and no state change
		dir_beat(OP_TICK, 8'hFF, 8'h7F, 1'b0, 1'b0, '0);
		// table write with engine_on low still lands
		dir_beat(OP_WRITE, 8'h00, 8'h7F, 1'b0, 1'b0, '0);
		dir_reg(CFG_VOL_A, 16'h00FF);
		dir_reg(CFG_VOL_B, 16'h00FF);
		dir_reg(CFG_VOL_C, 16'h00FF);
		// three full-scale voices on entry zero, then the lowest and mid values
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b1, 11'd1524);
		dir_beat(OP_WRITE, 8'h00, 8'h80, 1'b1, 1'b0, '0);
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b1, 11'd0);
		dir_beat(OP_WRITE, 8'h00, 8'h00, 1'b1, 1'b0, '0);
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b1, 11'd765);
		// noise in long mode, clocked on every tick
		dir_reg(CFG_NOISE_VOL, 16'h00FF);
		dir_reg(CFG_NOISE_CTRL, 16'h0001);
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b0, '0);
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b0, '0);
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b0, '0);
		// short mode with the slowest divider; largest steps wrap the phases
		dir_reg(CFG_NOISE_CTRL, 16'h00FE);
		dir_reg(CFG_STEP_A, 16'hFFFF);
		dir_reg(CFG_STEP_B, 16'h8000);
		dir_reg(CFG_STEP_C, 16'h0100);
		dir_beat(OP_WRITE, 8'hFF, 8'h7F, 1'b1, 1'b0, '0);
		dir_beat(OP_WRITE, 8'h80, 8'h80, 1'b0, 1'b0, '0);
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b0, '0);
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b0, '0);
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b0, '0);
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b0, 1'b0, '0);
		dir_beat(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b0, '0);

		// reset once
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill the whole table so that no tick reads an unwritten entry
		for (n = 0; n < WAVE_DEPTH; n++) begin
			send_beat(OP_WRITE, WAVE_AW'(n), WAVE_W'($urandom), 1'($urandom), 1'b0, '0);
		end

		// walk the directed table; registers change only once the pipe is empty
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_REG) begin
				if (!cfg_we) begin
					wait_drained();
				end
				reg_write(dir_rows[r].reg_idx, dir_rows[r].reg_data);
			end else begin
				send_beat(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].val, dir_rows[r].eng,
					dir_rows[r].known, dir_rows[r].known_smp);
			end
		end

		// random phases, each with its own settings and idle pattern
		quota = RAND_BEATS / NUM_PHASES;
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
				1: load_regs(16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				2, 3: load_regs(CFG_W'($urandom_range(16'h0400)),
					CFG_W'($urandom_range(16'h0400)), CFG_W'($urandom_range(16'h0400)),
					8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				default: load_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			idle_mode = idle_mode_t'(ph % 4);
			// hold the output off for a long stretch while beats keep coming
			if (ph == 4) begin
				rx_hold_left = HOLD_CYCLES;
			end
			n = 0;
			while (n < quota) begin
				random_beat(counted);
				if (counted) begin
					n++;
				end
				// pause the input mid-phase until every sample is out
				if (ph == 4 && n == quota / 2 && counted) begin
					wait_drained();
				end
			end
		end

		wait_drained();
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
